// ===== sv/arpc_pkg.sv =====
`default_nettype none
package arpc_pkg;

  localparam int unsigned IP_W  = 32;
  localparam int unsigned MAC_W = 48;
  localparam int unsigned LEN_W = 11;
  localparam int unsigned OP_W  = 16;

  localparam logic [LEN_W-1:0] ARP_HEADER_BYTES = LEN_W'(28);
  localparam logic [OP_W-1:0]  OPCODE_REQUEST   = OP_W'(1);
  localparam logic             KIND_PACKET      = 1'b0;
  localparam logic             KIND_LOOKUP      = 1'b1;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } arpc_entry_t;

  typedef struct packed {
    logic hit;
    logic free;
  } arpc_probe_t;

endpackage
`default_nettype wire

// ===== sv/arp_cache_learn_and_reply.sv =====
// ARP binding cache: learns sender IP-to-MAC bindings from received ARP
// packets, answers lookups and flags requests aimed at own_ip.
//
// Input: a transaction is taken when start is high and busy is low; all
// payload ports are sampled at that edge. busy stays high until the work is
// done. Configuration: own_ip is written by cfg_we_i/cfg_wdata_i; the user
// must write it only while the block is idle; the block does not enforce it.
// Result: exactly one per transaction, shown for one cycle with done_o high.
// The receiver cannot stall; a result is simply presented once.
// Timing: a short packet gives its result in the cycle after acceptance. Other
// items walk the table through one shared compare unit, each entry in a
// table RAM read state followed by a compare state, stopping at the first
// match or after the last of the TABLE_ENTRIES entries, and a new item may be
// accepted in the cycle the result is shown.
// Reset: valid bits clear at once, so the table is empty immediately; no
// clearing pass is needed. own_ip resets to 0.
`default_nettype none
module arp_cache_learn_and_reply #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          cfg_we_i,
  input  wire logic [arpc_pkg::IP_W-1:0]     cfg_wdata_i,
  input  wire logic                          kind_i,
  input  wire logic [arpc_pkg::LEN_W-1:0]    frame_length_i,
  input  wire logic [arpc_pkg::OP_W-1:0]     operation_i,
  input  wire logic [arpc_pkg::IP_W-1:0]     sender_ip_i,
  input  wire logic [arpc_pkg::MAC_W-1:0]    sender_mac_i,
  input  wire logic [arpc_pkg::IP_W-1:0]     req_dst_ip_i,
  input  wire logic [arpc_pkg::IP_W-1:0]     lookup_ip_i,
  output logic                               done_o,
  output logic                               dropped_o,
  output logic                               send_reply_o,
  output logic      [arpc_pkg::MAC_W-1:0]    reply_dest_mac_o,
  output logic      [arpc_pkg::IP_W-1:0]     reply_dst_ip_o,
  output logic                               lookup_hit_o,
  output logic      [arpc_pkg::MAC_W-1:0]    found_mac_o
);

  import arpc_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_RESOLVE
  } state_e;

  state_e                   state_q;
  logic [IP_W-1:0]          own_ip_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [IDX_W-1:0]         idx_q;
  logic                     lookup_q;
  logic                     request_q;
  logic [IP_W-1:0]          key_q;
  logic [IP_W-1:0]          req_dst_ip_q;
  logic [MAC_W-1:0]         mac_q;
  logic                     match_q;
  logic [IDX_W-1:0]         match_idx_q;
  logic [MAC_W-1:0]         match_mac_q;
  logic                     free_q;
  logic [IDX_W-1:0]         free_idx_q;

  arpc_entry_t rd_entry;
  arpc_entry_t wr_entry;
  arpc_probe_t probe;
  logic        ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic        ram_re;

  assign busy = (state_q != ST_IDLE);

  assign ram_re    = (state_q == ST_READ);
  assign ram_we    = (state_q == ST_RESOLVE) && !lookup_q && (match_q || free_q);
  assign ram_waddr = match_q ? match_idx_q : free_idx_q;
  assign wr_entry  = '{ip: key_q, mac: mac_q};

  arpc_ram #(
    .WIDTH($bits(arpc_entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wr_entry),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(rd_entry)
  );

  arpc_probe u_probe (
    .entry_i(rd_entry),
    .valid_i(valid_q[idx_q]),
    .key_i  (key_q),
    .probe_o(probe)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      own_ip_q          <= '0;
      valid_q           <= '0;
      idx_q             <= '0;
      lookup_q          <= 1'b0;
      request_q         <= 1'b0;
      key_q             <= '0;
      req_dst_ip_q      <= '0;
      mac_q             <= '0;
      match_q           <= 1'b0;
      match_idx_q       <= '0;
      match_mac_q       <= '0;
      free_q            <= 1'b0;
      free_idx_q        <= '0;
      done_o            <= 1'b0;
      dropped_o         <= 1'b0;
      send_reply_o      <= 1'b0;
      reply_dest_mac_o  <= '0;
      reply_dst_ip_o    <= '0;
      lookup_hit_o      <= 1'b0;
      found_mac_o       <= '0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) begin
        own_ip_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            lookup_q     <= (kind_i == KIND_LOOKUP);
            request_q    <= (operation_i == OPCODE_REQUEST);
            key_q        <= (kind_i == KIND_LOOKUP) ? lookup_ip_i : sender_ip_i;
            req_dst_ip_q <= req_dst_ip_i;
            mac_q        <= sender_mac_i;
            idx_q        <= '0;
            match_q      <= 1'b0;
            free_q       <= 1'b0;
            if (kind_i == KIND_PACKET && frame_length_i < ARP_HEADER_BYTES) begin
              done_o            <= 1'b1;
              dropped_o         <= 1'b1;
              send_reply_o      <= 1'b0;
              reply_dest_mac_o  <= '0;
              reply_dst_ip_o    <= '0;
              lookup_hit_o      <= 1'b0;
              found_mac_o       <= '0;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (probe.hit) begin
            match_q     <= 1'b1;
            match_idx_q <= idx_q;
            match_mac_q <= rd_entry.mac;
          end
          if (probe.free && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= idx_q;
          end
          if (probe.hit || idx_q == LAST_IDX) begin
            state_q <= ST_RESOLVE;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_READ;
          end
        end
        ST_RESOLVE: begin
          if (!lookup_q && !match_q && free_q) begin
            valid_q[free_idx_q] <= 1'b1;
          end
          done_o    <= 1'b1;
          dropped_o <= 1'b0;
          if (lookup_q) begin
            send_reply_o      <= 1'b0;
            reply_dest_mac_o  <= '0;
            reply_dst_ip_o    <= '0;
            lookup_hit_o      <= match_q;
            found_mac_o       <= match_q ? match_mac_q : '0;
          end else begin
            lookup_hit_o <= 1'b0;
            found_mac_o  <= '0;
            if (request_q && req_dst_ip_q == own_ip_q) begin
              send_reply_o      <= 1'b1;
              reply_dest_mac_o  <= mac_q;
              reply_dst_ip_o    <= key_q;
            end else begin
              send_reply_o      <= 1'b0;
              reply_dest_mac_o  <= '0;
              reply_dst_ip_o    <= '0;
            end
          end
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/arpc_ram.sv =====
`default_nettype none
module arpc_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== sv/arpc_probe.sv =====
`default_nettype none
module arpc_probe (
  input  wire arpc_pkg::arpc_entry_t        entry_i,
  input  wire logic                         valid_i,
  input  wire logic [arpc_pkg::IP_W-1:0]    key_i,
  output arpc_pkg::arpc_probe_t             probe_o
);

  import arpc_pkg::*;

  always_comb begin
    probe_o.hit  = valid_i && (entry_i.ip == key_i);
    probe_o.free = !valid_i;
  end

endmodule
`default_nettype wire
